[rtl/core/event_timer_scheduler_macros.svh]
// Assertion macros used by the scheduler checker
`ifndef EVENT_TIMER_SCHEDULER_MACROS_SVH
`define EVENT_TIMER_SCHEDULER_MACROS_SVH

// A consequent that must hold in the same cycle as its antecedent
`define ETS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// A stalled item stays valid and keeps its payload
`define ETS_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, pay) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && stl) |=> \
		(vld && $stable(pay))) else $error("stalled item changed");

`endif

[rtl/core/ets_pkg.sv]
package ets_pkg;

	localparam logic [2:0] CMD_POST     = 3'd0;
	localparam logic [2:0] CMD_TIMEOUT  = 3'd1;
	localparam logic [2:0] CMD_INTERVAL = 3'd2;
	localparam logic [2:0] CMD_CLEAR    = 3'd3;
	localparam logic [2:0] CMD_REQ_FRM  = 3'd4;
	localparam logic [2:0] CMD_CAN_FRM  = 3'd5;
	localparam logic [2:0] CMD_RUN      = 3'd6;

	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_RAN_TASK  = 3'd1;
	localparam logic [2:0] ST_FIRED     = 3'd2;
	localparam logic [2:0] ST_RAN_FRAME = 3'd3;
	localparam logic [2:0] ST_NOTHING   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_QUITTING  = 3'd6;

	localparam logic CFG_QUIT         = 1'b0;
	localparam logic CFG_FRAME_PERIOD = 1'b1;

	localparam logic [9:0]  FRAME_PERIOD_RST = 10'd16;
	localparam logic [31:0] ID_RST           = 32'd1;
	localparam logic [47:0] CLOCK_MAX        = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] handle;
		logic [31:0] amount;
		logic [31:0] target_id;
		logic        ready_only;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_handle;
		logic [31:0] out_id;
		logic [47:0] time_now;
		logic        pending;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [47:0] fire_at;
		logic [31:0] interval;
		logic [15:0] handle;
	} timer_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] handle;
	} frame_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_TASK_DAT,
		S_TSCAN,
		S_TDEC,
		S_TCLR,
		S_FCAN,
		S_FRD,
		S_FDAT,
		S_EMIT
	} state_t;

	// saturating add onto the 48-bit clock
	function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[48] ? CLOCK_MAX : s[47:0];
	endfunction

endpackage

[rtl/core/ets_ram.sv]
module ets_ram #(
	parameter int W = 16,
	parameter int D = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/event_timer_scheduler.sv]
// Event scheduler: a task queue, a timer table and a frame list, each held in a
// single-port-read synchronous RAM, driven by one sequencer that handles one
// item at a time. Post, add-timer, frame request, unused commands and run steps
// that report quitting pass from decode straight to emit, and a run step that
// serves a task reads the task RAM in between. Clear timer scans every slot
// through the RAM read port, and a run step that reaches the timer table scans
// every slot before it decides. Cancel frame compacts the list. A run step that
// renders frames reads each frame request in turn, one result each. Results
// leave through an output register, so any result may wait on rsp_stall without
// blocking the next item's acceptance once the current item has finished.
module event_timer_scheduler #(
	parameter int TASK_DEPTH = 16,
	parameter int TIMER_SLOTS = 16,
	parameter int FRAME_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ets_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ets_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [9:0]    cfg_data
);

	localparam int TW  = $clog2(TASK_DEPTH);
	localparam int TCW = $clog2(TASK_DEPTH + 1);
	localparam int MW  = $clog2(TIMER_SLOTS);
	localparam int MCW = $clog2(TIMER_SLOTS + 1);
	localparam int FW  = ($clog2(FRAME_SLOTS) > 0) ? $clog2(FRAME_SLOTS) : 1;
	localparam int FCW = $clog2(FRAME_SLOTS + 1);
	localparam int TMW = $bits(ets_pkg::timer_t);
	localparam int FMW = $bits(ets_pkg::frame_t);

	ets_pkg::state_t state_q, state_nx;

	logic               quit_q;
	logic [9:0]         period_q;
	logic [47:0]        clock_q;
	logic [31:0]        id_ctr_q;
	logic [TW-1:0]      head_q, tail_q;
	logic [TCW-1:0]     task_cnt_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [FCW-1:0]     frame_cnt_q, n_q, fsc_q, fj_q;
	logic [MCW-1:0]     tsc_q;
	logic               rd_v_s1;
	logic [MW-1:0]      rd_tidx_s1;
	logic               rsp_valid_q;
	ets_pkg::rsp_t      rsp_q;

	ets_pkg::req_t      req_q;
	logic [2:0]         em_status_q;
	logic [15:0]        em_handle_q;
	logic [31:0]        em_id_q;
	logic               em_last_q, em_more_q;
	logic               found_q;
	logic [MW-1:0]      best_idx_q;
	ets_pkg::timer_t    best_q;

	// memory ports
	logic               task_we;
	logic [15:0]        task_rdata;
	logic               tm_we;
	logic [MW-1:0]      tm_waddr;
	ets_pkg::timer_t    tm_wdata, tm_rdata;
	logic               fr_we;
	logic [FW-1:0]      fr_waddr, fr_raddr;
	ets_pkg::frame_t    fr_wdata, fr_rdata;

	logic               accept, out_free, task_full, tm_full, fr_full;
	logic [MW-1:0]      free_idx;
	logic               tscan_done, fcan_done, fire_ok, better, is_last;
	logic               scan_rd;
	logic [47:0]        new_clk;
	logic [31:0]        add_iv, add_delay;
	logic [2:0]         dec_status;
	logic [31:0]        dec_id;

	assign accept    = req_valid && (state_q == ets_pkg::S_IDLE);
	assign req_stall = (state_q != ets_pkg::S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign task_full = (task_cnt_q == TCW'(TASK_DEPTH));
	assign tm_full   = &valid_q;
	assign fr_full   = (frame_cnt_q == FCW'(FRAME_SLOTS));

	always_comb begin
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = MW'(i);
			end
		end
	end

	assign add_iv    = (req_q.cmd == ets_pkg::CMD_INTERVAL) ?
		((req_q.amount == '0) ? 32'd1 : req_q.amount) : '0;
	assign add_delay = (req_q.cmd == ets_pkg::CMD_INTERVAL) ? add_iv : req_q.amount;

	assign tscan_done = (tsc_q == MCW'(TIMER_SLOTS)) && !rd_v_s1;
	assign fcan_done  = (fsc_q == frame_cnt_q) && !rd_v_s1;
	assign scan_rd = (((state_q == ets_pkg::S_TSCAN) || (state_q == ets_pkg::S_TCLR)) &&
		(tsc_q < MCW'(TIMER_SLOTS))) ||
		((state_q == ets_pkg::S_FCAN) && (fsc_q < frame_cnt_q));
	assign better = !found_q || (tm_rdata.fire_at < best_q.fire_at) ||
		((tm_rdata.fire_at == best_q.fire_at) && (tm_rdata.id < best_q.id));
	assign fire_ok = found_q && (!req_q.ready_only || (best_q.fire_at <= clock_q));
	assign new_clk = (best_q.fire_at > clock_q) ? best_q.fire_at : clock_q;
	assign is_last = (fsc_q == n_q - 1'b1);

	// first result of a decoded item
	always_comb begin
		dec_status = ets_pkg::ST_ACCEPTED;
		dec_id     = '0;
		case (req_q.cmd)
			ets_pkg::CMD_POST: begin
				if (task_full) dec_status = ets_pkg::ST_FULL;
			end
			ets_pkg::CMD_TIMEOUT, ets_pkg::CMD_INTERVAL: begin
				if (tm_full) dec_status = ets_pkg::ST_FULL;
				else dec_id = id_ctr_q;
			end
			ets_pkg::CMD_REQ_FRM: begin
				if (fr_full) dec_status = ets_pkg::ST_FULL;
				else dec_id = id_ctr_q;
			end
			ets_pkg::CMD_RUN: begin
				dec_status = quit_q ? ets_pkg::ST_QUITTING : ets_pkg::ST_RAN_TASK;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ets_pkg::S_IDLE: begin
				if (accept) state_nx = ets_pkg::S_DECODE;
			end
			ets_pkg::S_DECODE: begin
				case (req_q.cmd)
					ets_pkg::CMD_RUN: begin
						if (quit_q) state_nx = ets_pkg::S_EMIT;
						else if (task_cnt_q != '0) state_nx = ets_pkg::S_TASK_DAT;
						else state_nx = ets_pkg::S_TSCAN;
					end
					ets_pkg::CMD_CLEAR:   state_nx = ets_pkg::S_TCLR;
					ets_pkg::CMD_CAN_FRM: state_nx = ets_pkg::S_FCAN;
					default:              state_nx = ets_pkg::S_EMIT;
				endcase
			end
			ets_pkg::S_TASK_DAT: state_nx = ets_pkg::S_EMIT;
			ets_pkg::S_TSCAN: begin
				if (tscan_done) state_nx = ets_pkg::S_TDEC;
			end
			ets_pkg::S_TDEC: begin
				if (!fire_ok && frame_cnt_q != '0) state_nx = ets_pkg::S_FRD;
				else state_nx = ets_pkg::S_EMIT;
			end
			ets_pkg::S_TCLR: begin
				if (tscan_done) state_nx = ets_pkg::S_EMIT;
			end
			ets_pkg::S_FCAN: begin
				if (fcan_done) state_nx = ets_pkg::S_EMIT;
			end
			ets_pkg::S_FRD:  state_nx = ets_pkg::S_FDAT;
			ets_pkg::S_FDAT: state_nx = ets_pkg::S_EMIT;
			ets_pkg::S_EMIT: begin
				if (out_free) state_nx = em_more_q ? ets_pkg::S_FRD : ets_pkg::S_IDLE;
			end
			default: state_nx = ets_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		task_we  = 1'b0;
		tm_we    = 1'b0;
		tm_waddr = free_idx;
		tm_wdata = '{id: id_ctr_q, fire_at: ets_pkg::sat_add(clock_q, add_delay),
			interval: add_iv, handle: req_q.handle};
		fr_we    = 1'b0;
		fr_waddr = frame_cnt_q[FW-1:0];
		fr_wdata = '{id: id_ctr_q, handle: req_q.handle};
		fr_raddr = fsc_q[FW-1:0];
		case (state_q)
			ets_pkg::S_DECODE: begin
				task_we = (req_q.cmd == ets_pkg::CMD_POST) && !task_full;
				tm_we   = ((req_q.cmd == ets_pkg::CMD_TIMEOUT) ||
					(req_q.cmd == ets_pkg::CMD_INTERVAL)) && !tm_full;
				fr_we   = (req_q.cmd == ets_pkg::CMD_REQ_FRM) && !fr_full;
			end
			ets_pkg::S_TDEC: begin
				tm_we    = fire_ok && (best_q.interval != '0);
				tm_waddr = best_idx_q;
				tm_wdata = best_q;
				tm_wdata.fire_at = ets_pkg::sat_add(new_clk, best_q.interval);
			end
			ets_pkg::S_FCAN: begin
				fr_we    = rd_v_s1 && (fr_rdata.id != req_q.target_id);
				fr_waddr = fj_q[FW-1:0];
				fr_wdata = fr_rdata;
			end
			default: ;
		endcase
	end

	ets_ram #(.W(16), .D(TASK_DEPTH), .AW(TW)) u_task_ram (
		.clk(clk), .we(task_we), .waddr(tail_q), .wdata(req_q.handle),
		.raddr(head_q), .rdata(task_rdata)
	);

	ets_ram #(.W(TMW), .D(TIMER_SLOTS), .AW(MW)) u_timer_ram (
		.clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
		.raddr(tsc_q[MW-1:0]), .rdata(tm_rdata)
	);

	ets_ram #(.W(FMW), .D(FRAME_SLOTS), .AW(FW)) u_frame_ram (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ets_pkg::S_IDLE;
			quit_q      <= 1'b0;
			period_q    <= ets_pkg::FRAME_PERIOD_RST;
			clock_q     <= '0;
			id_ctr_q    <= ets_pkg::ID_RST;
			head_q      <= '0;
			tail_q      <= '0;
			task_cnt_q  <= '0;
			valid_q     <= '0;
			frame_cnt_q <= '0;
			n_q         <= '0;
			fsc_q       <= '0;
			fj_q        <= '0;
			tsc_q       <= '0;
			rd_v_s1     <= 1'b0;
			rd_tidx_s1  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					ets_pkg::CFG_QUIT:         quit_q   <= cfg_data[0];
					ets_pkg::CFG_FRAME_PERIOD: period_q <= cfg_data;
					default: ;
				endcase
			end
			rd_v_s1    <= scan_rd;
			rd_tidx_s1 <= tsc_q[MW-1:0];
			case (state_q)
				ets_pkg::S_DECODE: begin
					tsc_q <= '0;
					fsc_q <= '0;
					fj_q  <= '0;
					case (req_q.cmd)
						ets_pkg::CMD_POST: begin
							if (!task_full) begin
								tail_q <= (tail_q == TW'(TASK_DEPTH - 1)) ? '0 : tail_q + 1'b1;
								task_cnt_q <= task_cnt_q + 1'b1;
							end
						end
						ets_pkg::CMD_TIMEOUT, ets_pkg::CMD_INTERVAL: begin
							if (!tm_full) begin
								valid_q[free_idx] <= 1'b1;
								id_ctr_q <= id_ctr_q + 1'b1;
							end
						end
						ets_pkg::CMD_REQ_FRM: begin
							if (!fr_full) begin
								frame_cnt_q <= frame_cnt_q + 1'b1;
								id_ctr_q <= id_ctr_q + 1'b1;
							end
						end
						ets_pkg::CMD_RUN: begin
							if (!quit_q && task_cnt_q != '0) begin
								head_q <= (head_q == TW'(TASK_DEPTH - 1)) ? '0 : head_q + 1'b1;
								task_cnt_q <= task_cnt_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				ets_pkg::S_TSCAN, ets_pkg::S_TCLR: begin
					if (tsc_q < MCW'(TIMER_SLOTS)) begin
						tsc_q <= tsc_q + 1'b1;
					end
					if (state_q == ets_pkg::S_TCLR && rd_v_s1 && valid_q[rd_tidx_s1] &&
						tm_rdata.id == req_q.target_id) begin
						valid_q[rd_tidx_s1] <= 1'b0;
					end
				end
				ets_pkg::S_TDEC: begin
					if (fire_ok) begin
						clock_q <= new_clk;
						if (best_q.interval == '0) valid_q[best_idx_q] <= 1'b0;
					end else if (frame_cnt_q != '0) begin
						n_q         <= frame_cnt_q;
						frame_cnt_q <= '0;
						fsc_q       <= '0;
						if (!req_q.ready_only) clock_q <= ets_pkg::sat_add(clock_q, {22'b0, period_q});
					end
				end
				ets_pkg::S_FCAN: begin
					if (fsc_q < frame_cnt_q) begin
						fsc_q   <= fsc_q + 1'b1;
					end
					if (rd_v_s1 && fr_rdata.id != req_q.target_id) fj_q <= fj_q + 1'b1;
					if (fcan_done) frame_cnt_q <= fj_q;
				end
				ets_pkg::S_FDAT: fsc_q <= fsc_q + 1'b1;
				default: ;
			endcase
			if (state_q == ets_pkg::S_EMIT && out_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		case (state_q)
			ets_pkg::S_DECODE: begin
				em_status_q <= dec_status;
				em_handle_q <= '0;
				em_id_q     <= dec_id;
				em_last_q   <= 1'b1;
				em_more_q   <= 1'b0;
				found_q     <= 1'b0;
			end
			ets_pkg::S_TASK_DAT: em_handle_q <= task_rdata;
			ets_pkg::S_TSCAN: begin
				if (rd_v_s1 && valid_q[rd_tidx_s1] && better) begin
					found_q    <= 1'b1;
					best_idx_q <= rd_tidx_s1;
					best_q     <= tm_rdata;
				end
			end
			ets_pkg::S_TDEC: begin
				if (fire_ok) begin
					em_status_q <= ets_pkg::ST_FIRED;
					em_handle_q <= best_q.handle;
					em_id_q     <= best_q.id;
				end else begin
					em_status_q <= ets_pkg::ST_NOTHING;
				end
			end
			ets_pkg::S_FDAT: begin
				em_status_q <= ets_pkg::ST_RAN_FRAME;
				em_handle_q <= fr_rdata.handle;
				em_id_q     <= fr_rdata.id;
				em_last_q   <= is_last;
				em_more_q   <= !is_last;
			end
			ets_pkg::S_EMIT: begin
				if (out_free) begin
					rsp_q.status     <= em_status_q;
					rsp_q.out_handle <= em_handle_q;
					rsp_q.out_id     <= em_id_q;
					rsp_q.time_now   <= clock_q;
					rsp_q.pending    <= (task_cnt_q != '0) || (frame_cnt_q != '0) || (|valid_q);
					rsp_q.last       <= em_last_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/ets_checker.sv]
`include "event_timer_scheduler_macros.svh"

module ets_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ets_pkg::rsp_t rsp
);

	`ETS_ASSERT_HOLD(a_rsp_hold, clk, arst_n, rsp_valid, rsp_stall, rsp)
	`ETS_ASSERT_NOW(a_status_code, clk, arst_n, rsp_valid, rsp.status <= ets_pkg::ST_QUITTING)
	`ETS_ASSERT_NOW(a_single_last, clk, arst_n, rsp_valid && rsp.status != ets_pkg::ST_RAN_FRAME, rsp.last)
	`ETS_ASSERT_NOW(a_full_pending, clk, arst_n, rsp_valid && rsp.status == ets_pkg::ST_FULL, rsp.pending)

endmodule

bind event_timer_scheduler ets_checker u_ets_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);

[tb/sv/event_timer_scheduler_test.sv]
module event_timer_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_TASKS    = 16;
	localparam int          N_TIMERS   = 16;
	localparam int          N_FRAMES   = 16;
	localparam logic [2:0]  CMD_UNUSED = 3'd7;
	localparam int          LIMIT      = 1000000;
	localparam int          SETTLE     = 48;

	class sched_model;
		logic        quit_on;
		logic [9:0]  period;
		logic [47:0] clk_ms;
		logic [31:0] id_ctr;
		logic [15:0] tasks[$];
		ets_pkg::frame_t frames[$];
		logic        t_valid[N_TIMERS];
		ets_pkg::timer_t timers[N_TIMERS];
		ets_pkg::rsp_t   exp_rsp[$];
		int          errors;
		int          checked;
		int          fired;
		int          full_hits;

		function new();
			quit_on = 1'b0;
			period = ets_pkg::FRAME_PERIOD_RST;
			clk_ms = '0;
			id_ctr = ets_pkg::ID_RST;
			errors = 0;
			checked = 0;
			fired = 0;
			full_hits = 0;
			foreach (t_valid[i]) t_valid[i] = 1'b0;
		endfunction

		function void set_reg(logic idx, logic [9:0] val);
			if (idx == ets_pkg::CFG_QUIT) quit_on = val[0];
			else period = val;
		endfunction

		function logic [47:0] clamp_add(logic [47:0] a, logic [31:0] b);
			logic [63:0] s;
			s = {16'b0, a} + {32'b0, b};
			return (s > {16'b0, ets_pkg::CLOCK_MAX}) ? ets_pkg::CLOCK_MAX : s[47:0];
		endfunction

		function void put(logic [2:0] st, logic [15:0] h, logic [31:0] id, logic lst);
			ets_pkg::rsp_t e;
			logic busy;
			busy = (tasks.size() > 0) || (frames.size() > 0);
			foreach (t_valid[i]) if (t_valid[i]) busy = 1'b1;
			e.status = st;
			e.out_handle = h;
			e.out_id = id;
			e.time_now = clk_ms;
			e.pending = busy;
			e.last = lst;
			if (st == ets_pkg::ST_FULL) full_hits++;
			exp_rsp.insert(exp_rsp.size(), e);
		endfunction

		function void add_timer(logic [15:0] h, logic [31:0] iv, logic [31:0] delay);
			for (int i = 0; i < N_TIMERS; i++) begin
				if (!t_valid[i]) begin
					t_valid[i] = 1'b1;
					timers[i].id = id_ctr;
					timers[i].fire_at = clamp_add(clk_ms, delay);
					timers[i].interval = iv;
					timers[i].handle = h;
					id_ctr = id_ctr + 32'd1;
					put(ets_pkg::ST_ACCEPTED, '0, timers[i].id, 1'b1);
					return;
				end
			end
			put(ets_pkg::ST_FULL, '0, '0, 1'b1);
		endfunction

		function void run_step(logic ready);
			int best;
			ets_pkg::frame_t batch[$];
			logic [15:0] h;
			best = -1;
			if (quit_on) begin
				put(ets_pkg::ST_QUITTING, '0, '0, 1'b1);
				return;
			end
			if (tasks.size() > 0) begin
				h = tasks[0];
				tasks.delete(0);
				put(ets_pkg::ST_RAN_TASK, h, '0, 1'b1);
				return;
			end
			for (int i = 0; i < N_TIMERS; i++) begin
				if (!t_valid[i]) continue;
				if (best < 0 || timers[i].fire_at < timers[best].fire_at ||
				    (timers[i].fire_at == timers[best].fire_at &&
				     timers[i].id < timers[best].id))
					best = i;
			end
			if (best >= 0 && (!ready || timers[best].fire_at <= clk_ms)) begin
				if (timers[best].fire_at > clk_ms) clk_ms = timers[best].fire_at;
				if (timers[best].interval != 0)
					timers[best].fire_at = clamp_add(clk_ms, timers[best].interval);
				else
					t_valid[best] = 1'b0;
				fired++;
				put(ets_pkg::ST_FIRED, timers[best].handle, timers[best].id, 1'b1);
				return;
			end
			if (frames.size() > 0) begin
				batch = frames;
				frames.delete();
				if (!ready) clk_ms = clamp_add(clk_ms, {22'b0, period});
				foreach (batch[i])
					put(ets_pkg::ST_RAN_FRAME, batch[i].handle, batch[i].id,
					    i == batch.size() - 1);
				return;
			end
			put(ets_pkg::ST_NOTHING, '0, '0, 1'b1);
		endfunction

		function void note_cmd(ets_pkg::req_t r);
			ets_pkg::frame_t kept[$];
			ets_pkg::frame_t f;
			case (r.cmd)
				ets_pkg::CMD_POST: begin
					if (tasks.size() >= N_TASKS) begin
						put(ets_pkg::ST_FULL, '0, '0, 1'b1);
					end else begin
						tasks.insert(tasks.size(), r.handle);
						put(ets_pkg::ST_ACCEPTED, '0, '0, 1'b1);
					end
				end
				ets_pkg::CMD_TIMEOUT: add_timer(r.handle, '0, r.amount);
				ets_pkg::CMD_INTERVAL: begin
					if (r.amount == 0) add_timer(r.handle, 32'd1, 32'd1);
					else add_timer(r.handle, r.amount, r.amount);
				end
				ets_pkg::CMD_CLEAR: begin
					foreach (t_valid[i])
						if (t_valid[i] && timers[i].id == r.target_id) t_valid[i] = 1'b0;
					put(ets_pkg::ST_ACCEPTED, '0, '0, 1'b1);
				end
				ets_pkg::CMD_REQ_FRM: begin
					if (frames.size() >= N_FRAMES) begin
						put(ets_pkg::ST_FULL, '0, '0, 1'b1);
					end else begin
						f.id = id_ctr;
						f.handle = r.handle;
						frames.insert(frames.size(), f);
						id_ctr = id_ctr + 32'd1;
						put(ets_pkg::ST_ACCEPTED, '0, f.id, 1'b1);
					end
				end
				ets_pkg::CMD_CAN_FRM: begin
					foreach (frames[i])
						if (frames[i].id != r.target_id) kept.insert(kept.size(), frames[i]);
					frames = kept;
					put(ets_pkg::ST_ACCEPTED, '0, '0, 1'b1);
				end
				ets_pkg::CMD_RUN: run_step(r.ready_only);
				default: put(ets_pkg::ST_ACCEPTED, '0, '0, 1'b1);
			endcase
		endfunction

		function void check_rsp(ets_pkg::rsp_t got);
			ets_pkg::rsp_t e;
			checked++;
			if (exp_rsp.size() == 0) begin
				$error("unexpected result: status %0d id %0d", got.status, got.out_id);
				errors++;
				return;
			end
			e = exp_rsp[0];
			exp_rsp.delete(0);
			if (got.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, got.status);
				errors++;
			end
			if (got.out_handle !== e.out_handle) begin
				$error("out_handle expected %0h actual %0h", e.out_handle, got.out_handle);
				errors++;
			end
			if (got.out_id !== e.out_id) begin
				$error("out_id expected %0d actual %0d", e.out_id, got.out_id);
				errors++;
			end
			if (got.time_now !== e.time_now) begin
				$error("time_now expected %0d actual %0d", e.time_now, got.time_now);
				errors++;
			end
			if (got.pending !== e.pending) begin
				$error("pending expected %0b actual %0b", e.pending, got.pending);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last expected %0b actual %0b", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	ets_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	ets_pkg::rsp_t rsp;
	logic          cfg_we;
	logic          cfg_index;
	logic [9:0]    cfg_data;

	sched_model sb = new();
	int         n_items = 0;
	bit         fast = 0;
	bit         hold_req = 0;

	event_timer_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// receiver: random gaps per item, plus one long hold-off on request
	initial begin
		int gap;
		int hold;
		gap = 0;
		hold = 0;
		rsp_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				sb.check_rsp(rsp);
				gap = fast ? 0 : $urandom_range(0, 18);
			end
			if (hold_req) begin
				hold = 600;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send(ets_pkg::req_t r);
		int gap;
		gap = fast ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_cmd(r);
		n_items++;
	endtask

	task automatic send_cmd(logic [2:0] c, logic [15:0] h, logic [31:0] amt,
	                        logic [31:0] tgt, logic rdy);
		ets_pkg::req_t r;
		r.cmd = c;
		r.handle = h;
		r.amount = amt;
		r.target_id = tgt;
		r.ready_only = rdy;
		send(r);
	endtask

	// drain all expected results, then let the sequencer settle
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.exp_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(logic q, logic [9:0] p);
		cfg_we <= 1'b1;
		cfg_index <= ets_pkg::CFG_QUIT;
		cfg_data <= {9'b0, q};
		@(posedge clk);
		sb.set_reg(ets_pkg::CFG_QUIT, {9'b0, q});
		cfg_index <= ets_pkg::CFG_FRAME_PERIOD;
		cfg_data <= p;
		@(posedge clk);
		sb.set_reg(ets_pkg::CFG_FRAME_PERIOD, p);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] recent_id();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return sb.id_ctr - $urandom_range(1, 10);
	endfunction

	task automatic random_item();
		ets_pkg::req_t r;
		int p;
		r.handle = 16'($urandom);
		r.amount = $urandom;
		r.target_id = $urandom;
		r.ready_only = 1'($urandom_range(0, 1));
		p = $urandom_range(0, 99);
		if (p < 14) begin
			r.cmd = ets_pkg::CMD_POST;
		end else if (p < 28) begin
			r.cmd = ets_pkg::CMD_TIMEOUT;
			if ($urandom_range(0, 3) != 0) r.amount = $urandom_range(0, 100);
		end else if (p < 34) begin
			r.cmd = ets_pkg::CMD_INTERVAL;
			if ($urandom_range(0, 7) != 0) r.amount = $urandom_range(0, 40);
		end else if (p < 44) begin
			r.cmd = ets_pkg::CMD_CLEAR;
			r.target_id = recent_id();
		end else if (p < 56) begin
			r.cmd = ets_pkg::CMD_REQ_FRM;
		end else if (p < 63) begin
			r.cmd = ets_pkg::CMD_CAN_FRM;
			r.target_id = recent_id();
		end else if (p < 98) begin
			r.cmd = ets_pkg::CMD_RUN;
		end else begin
			r.cmd = CMD_UNUSED;
		end
		send(r);
	endtask

	task automatic random_phase(int count, bit long_hold);
		logic [2:0] c;
		fast = ($urandom_range(0, 3) == 0);
		if (long_hold) hold_req = 1;
		for (int i = 0; i < count; i++) begin
			// fill one store past its depth midway through the phase
			if (i == count / 2) begin
				case ($urandom_range(0, 2))
					0: c = ets_pkg::CMD_POST;
					1: c = ets_pkg::CMD_TIMEOUT;
					default: c = ets_pkg::CMD_REQ_FRM;
				endcase
				repeat (N_TASKS + 1)
					send_cmd(c, 16'($urandom), $urandom_range(0, 500), '0, 1'b0);
				repeat (N_TASKS + 2)
					send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'($urandom_range(0, 1)));
			end
			random_item();
		end
		fast = 0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = ets_pkg::CFG_QUIT;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		set_regs(1'b0, ets_pkg::FRAME_PERIOD_RST);

		send_cmd(ets_pkg::CMD_POST, 16'hFFFF, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_POST, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b1);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_TIMEOUT, 16'hABCD, 32'd0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_TIMEOUT, 16'h1234, 32'hFFFF_FFFF, '0, 1'b0);
		send_cmd(ets_pkg::CMD_INTERVAL, 16'h5555, 32'd0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b1);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b1);
		send_cmd(ets_pkg::CMD_CLEAR, '0, '0, sb.id_ctr - 32'd1, 1'b0);
		send_cmd(ets_pkg::CMD_CLEAR, '0, '0, 32'hFFFF_FFFF, 1'b0);
		send_cmd(ets_pkg::CMD_REQ_FRM, 16'h0001, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_REQ_FRM, 16'h0002, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_REQ_FRM, 16'h0003, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_CAN_FRM, '0, '0, 32'hFFFF_FFFF, 1'b0);
		send_cmd(ets_pkg::CMD_CAN_FRM, '0, '0, sb.id_ctr - 32'd2, 1'b0);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b1);
		send_cmd(ets_pkg::CMD_REQ_FRM, 16'hFFFF, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b0);
		send_cmd(ets_pkg::CMD_RUN, '0, '0, '0, 1'b0);
		send_cmd(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		drain();

		set_regs(1'b0, 10'd1);
		random_phase(40, 1'b0);
		set_regs(1'b0, 10'd1000);
		random_phase(40, 1'b1);
		set_regs(1'b1, 10'd0);
		random_phase(10, 1'b0);
		set_regs(1'b0, 10'd0);
		random_phase(35, 1'b0);
		set_regs(1'b0, 10'h3FF);
		random_phase(40, 1'b0);

		$display("Sent %0d items, checked %0d results (%0d timer fires, %0d store-full).",
		         n_items, sb.checked, sb.fired, sb.full_hits);
		$display("Covered task, timer and frame paths across quit and frame period settings.");
		if (sb.errors == 0 && sb.exp_rsp.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
